### rtl/tkss_pkg.sv
// Shared constants, types and helpers of the top-K score selector.
// No dependencies; every other file of the block but tkss_ram imports this package.
package tkss_pkg;

    localparam int MAX_K      = 16;
    localparam int KEY_BITS   = 16;
    localparam int SCORE_BITS = 32;

    localparam int IDX_W      = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CNT_W      = $clog2(MAX_K + 1);
    localparam int ENTRY_W    = KEY_BITS + SCORE_BITS;
    localparam int POS_W      = 4;
    localparam int KLIM_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_K_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDERED = 1'b1;

    localparam logic [KLIM_W-1:0] K_LIMIT_RST = 5'd16;
    localparam logic              ORDERED_RST = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] k_act;
        logic             ordered;
    } t_cfg;

    typedef struct packed {
        logic                  entry_valid;
        logic [KEY_BITS-1:0]   key;
        logic [SCORE_BITS-1:0] score;
        logic [POS_W-1:0]      position;
        logic                  last;
    } t_out_beat;

    function automatic logic [CNT_W-1:0] active_k(input logic [KLIM_W-1:0] k);
        logic [CNT_W-1:0] res;
        if (k == '0) begin
            res = CNT_W'(1);
        end else if (int'(k) > MAX_K) begin
            res = CNT_W'(MAX_K);
        end else begin
            res = CNT_W'(k);
        end
        return res;
    endfunction

endpackage

### rtl/top_k_score_selector_unit.sv
// Top level of the top-K score selector: config registers, heap sequencer
// and result register. Depends on tkss_pkg, tkss_cfg, tkss_seq and tkss_out.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------
//  in       | input     | i_in_valid / o_in_stall | i_req_type, i_key_id, i_score
//  out      | output    | o_out_valid/i_out_stall | o_entry_valid, o_out_key, o_out_score,
//           |           |                         | o_position, o_last
//  cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Offer: a rejected item ends at the root compare, else the item is sifted down one heap level per step.
//  Drain: when ordered, K-1 heapsort rounds of a swap and a sift, then a scan of K slots and one flush;
//  each sift level is one pass through the shared compare unit and the slot RAM ports.
//  Reset is synchronous; per-slot valid bits clear at once, so no clearing pass is needed.
//  o_in_stall is high while an item is in work; i_out_stall holds the scan.
module top_k_score_selector_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [tkss_pkg::KEY_BITS-1:0]     i_key_id,
    input  logic [tkss_pkg::SCORE_BITS-1:0]   i_score,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_entry_valid,
    output logic [tkss_pkg::KEY_BITS-1:0]     o_out_key,
    output logic [tkss_pkg::SCORE_BITS-1:0]   o_out_score,
    output logic [tkss_pkg::POS_W-1:0]        o_position,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tkss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tkss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tkss_pkg::*;

    t_cfg      cfg;
    logic      out_free;
    logic      out_load;
    t_out_beat out_beat;
    t_out_beat out_q;

    tkss_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tkss_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_req_type(i_req_type),
        .i_key_id  (i_key_id),
        .i_score   (i_score),
        .i_out_free(out_free),
        .o_out_load(out_load),
        .o_out_beat(out_beat)
    );

    tkss_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (out_load),
        .i_beat (out_beat),
        .i_stall(i_out_stall),
        .o_free (out_free),
        .o_valid(o_out_valid),
        .o_beat (out_q)
    );

    assign o_entry_valid = out_q.entry_valid;
    assign o_out_key     = out_q.key;
    assign o_out_score   = out_q.score;
    assign o_position    = out_q.position;
    assign o_last        = out_q.last;

endmodule

### rtl/tkss_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// A read of the address written in the same cycle returns the new data.
module tkss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wa,
    input  logic [WIDTH-1:0]                          i_wd,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_ra,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rb,
    output logic [WIDTH-1:0]                          o_qa,
    output logic [WIDTH-1:0]                          o_qb
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_qa;
    logic [WIDTH-1:0] r_qb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_we && (i_wa == i_ra)) begin
            r_qa <= i_wd;
        end else begin
            r_qa <= r_mem[i_ra];
        end
        if (i_we && (i_wa == i_rb)) begin
            r_qb <= i_wd;
        end else begin
            r_qb <= r_mem[i_rb];
        end
    end

    assign o_qa = r_qa;
    assign o_qb = r_qb;

endmodule

### rtl/tkss_cfg.sv
// Configuration registers of the top-K score selector and the clamp of K.
// Depends on tkss_pkg.
module tkss_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tkss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tkss_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tkss_pkg::t_cfg                      o_cfg
);
    import tkss_pkg::*;

    logic [KLIM_W-1:0] r_k_limit;
    logic              r_ordered;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_limit <= K_LIMIT_RST;
            r_ordered <= ORDERED_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_K_LIMIT: r_k_limit <= i_cfg_data[KLIM_W-1:0];
                CFG_ORDERED: r_ordered <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_cfg.k_act   = active_k(r_k_limit);
    assign o_cfg.ordered = r_ordered;

endmodule

### rtl/tkss_out.sv
// Output register of the result channel: holds one beat until taken.
// Depends on tkss_pkg.
module tkss_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  tkss_pkg::t_out_beat   i_beat,
    input  logic                  i_stall,
    output logic                  o_free,
    output logic                  o_valid,
    output tkss_pkg::t_out_beat   o_beat
);
    import tkss_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

### rtl/tkss_seq.sv
// Heap sequencer: slot store, shared compare unit, sift, heapsort and drain scan.
// Depends on tkss_pkg and tkss_ram.
module tkss_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tkss_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [tkss_pkg::KEY_BITS-1:0]   i_key_id,
    input  logic [tkss_pkg::SCORE_BITS-1:0] i_score,
    input  logic                            i_out_free,
    output logic                            o_out_load,
    output tkss_pkg::t_out_beat             o_out_beat
);
    import tkss_pkg::*;

    localparam int LW = IDX_W + 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ROOT  = 6'b000010,
        S_SIFT  = 6'b000100,
        S_SWAP  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic [CNT_W-1:0]      r_n, n_n;
    logic [CNT_W-1:0]      r_i, n_i;
    logic [KEY_BITS-1:0]   r_ckey, n_ckey;
    logic [SCORE_BITS-1:0] r_cscore, n_cscore;
    logic                  r_drain, n_drain;
    logic [MAX_K-1:0]      r_valid, n_valid;
    logic                  r_pend_v, n_pend_v;
    logic [KEY_BITS-1:0]   r_pkey, n_pkey;
    logic [SCORE_BITS-1:0] r_pscore, n_pscore;
    logic [POS_W-1:0]      r_cnt, n_cnt;
    logic                  r_va, n_va;
    logic                  r_vb, n_vb;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_wa;
    logic [ENTRY_W-1:0]    ram_wd;
    logic [IDX_W-1:0]      ram_ra;
    logic [IDX_W-1:0]      ram_rb;
    logic [ENTRY_W-1:0]    ram_qa;
    logic [ENTRY_W-1:0]    ram_qb;

    logic [KEY_BITS-1:0]   a_key, b_key;
    logic [SCORE_BITS-1:0] a_score, b_score;
    logic [LW-1:0]         lo, hi, n_ext;
    logic                  take_lo, take_hi;
    logic [IDX_W-1:0]      child;
    logic [LW-1:0]         child_lo, child_hi;
    logic                  found;
    logic [CNT_W:0]        scan_next;

    tkss_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_K)
    ) u_ram (
        .i_clk(i_clk),
        .i_we (ram_we),
        .i_wa (ram_wa),
        .i_wd (ram_wd),
        .i_ra (ram_ra),
        .i_rb (ram_rb),
        .o_qa (ram_qa),
        .o_qb (ram_qb)
    );

    assign a_key   = r_va ? ram_qa[ENTRY_W-1:SCORE_BITS] : '0;
    assign a_score = r_va ? ram_qa[SCORE_BITS-1:0] : '0;
    assign b_key   = r_vb ? ram_qb[ENTRY_W-1:SCORE_BITS] : '0;
    assign b_score = r_vb ? ram_qb[SCORE_BITS-1:0] : '0;

    assign lo      = LW'({r_cur, 1'b1});
    assign hi      = LW'({r_cur, 1'b0}) + LW'(2);
    assign n_ext   = LW'(r_n);
    assign take_lo = (lo < n_ext) && (a_score < r_cscore);
    assign take_hi = (hi < n_ext) && (b_score < (take_lo ? a_score : r_cscore));
    assign child   = take_hi ? hi[IDX_W-1:0] : lo[IDX_W-1:0];
    assign child_lo = LW'({child, 1'b1});
    assign child_hi = LW'({child, 1'b0}) + LW'(2);

    assign found     = (a_score != '0);
    assign scan_next = (CNT_W+1)'(r_i) + (CNT_W+1)'(1);

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_n      = r_n;
        n_i      = r_i;
        n_ckey   = r_ckey;
        n_cscore = r_cscore;
        n_drain  = r_drain;
        n_valid  = r_valid;
        n_pend_v = r_pend_v;
        n_pkey   = r_pkey;
        n_pscore = r_pscore;
        n_cnt    = r_cnt;
        ram_we   = 1'b0;
        ram_wa   = '0;
        ram_wd   = '0;
        ram_ra   = '0;
        ram_rb   = '0;
        o_out_load = 1'b0;
        o_out_beat = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_OFFER) begin
                        n_ckey   = i_key_id;
                        n_cscore = i_score;
                        n_n      = i_cfg.k_act;
                        n_drain  = 1'b0;
                        n_state  = S_ROOT;
                    end else begin
                        n_drain  = 1'b1;
                        n_pend_v = 1'b0;
                        n_cnt    = '0;
                        if (i_cfg.ordered && (i_cfg.k_act > CNT_W'(1))) begin
                            n_i     = i_cfg.k_act - CNT_W'(1);
                            ram_rb  = n_i[IDX_W-1:0];
                            n_state = S_SWAP;
                        end else begin
                            n_i     = '0;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_ROOT: begin
                if (r_cscore > a_score) begin
                    n_cur   = '0;
                    ram_ra  = IDX_W'(1);
                    ram_rb  = IDX_W'(2);
                    n_state = S_SIFT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SWAP: begin
                ram_we   = 1'b1;
                ram_wa   = r_i[IDX_W-1:0];
                ram_wd   = {a_key, a_score};
                n_ckey   = b_key;
                n_cscore = b_score;
                n_n      = r_i;
                n_cur    = '0;
                ram_ra   = IDX_W'(1);
                ram_rb   = IDX_W'(2);
                n_state  = S_SIFT;
            end
            S_SIFT: begin
                ram_we = 1'b1;
                ram_wa = r_cur;
                if (take_lo || take_hi) begin
                    ram_wd = take_hi ? {b_key, b_score} : {a_key, a_score};
                    n_cur  = child;
                    ram_ra = child_lo[IDX_W-1:0];
                    ram_rb = child_hi[IDX_W-1:0];
                end else begin
                    ram_wd = {r_ckey, r_cscore};
                    if (!r_drain) begin
                        n_state = S_IDLE;
                    end else if (r_i > CNT_W'(1)) begin
                        n_i     = r_i - CNT_W'(1);
                        ram_rb  = n_i[IDX_W-1:0];
                        n_state = S_SWAP;
                    end else begin
                        n_i     = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (found && r_pend_v && !i_out_free) begin
                    ram_ra = r_i[IDX_W-1:0];
                end else begin
                    if (found) begin
                        if (r_pend_v) begin
                            o_out_load = 1'b1;
                            o_out_beat = '{entry_valid: 1'b1, key: r_pkey, score: r_pscore,
                                           position: r_cnt, last: 1'b0};
                            n_cnt      = r_cnt + POS_W'(1);
                        end
                        n_pend_v = 1'b1;
                        n_pkey   = a_key;
                        n_pscore = a_score;
                    end
                    if (scan_next < (CNT_W+1)'(i_cfg.k_act)) begin
                        n_i    = scan_next[CNT_W-1:0];
                        ram_ra = scan_next[IDX_W-1:0];
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    if (r_pend_v) begin
                        o_out_beat = '{entry_valid: 1'b1, key: r_pkey, score: r_pscore,
                                       position: r_cnt, last: 1'b1};
                    end else begin
                        o_out_beat = '{entry_valid: 1'b0, key: '0, score: '0,
                                       position: '0, last: 1'b1};
                    end
                    n_valid = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (ram_we) begin
            n_valid[ram_wa] = 1'b1;
        end
        n_va = r_valid[ram_ra] || (ram_we && (ram_wa == ram_ra));
        n_vb = r_valid[ram_rb] || (ram_we && (ram_wa == ram_rb));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_pend_v <= 1'b0;
            r_drain  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_pend_v <= n_pend_v;
            r_drain  <= n_drain;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_n      <= n_n;
        r_i      <= n_i;
        r_ckey   <= n_ckey;
        r_cscore <= n_cscore;
        r_pkey   <= n_pkey;
        r_pscore <= n_pscore;
        r_va     <= n_va;
        r_vb     <= n_vb;
    end

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("slot store written while idle");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> (i_out_free && (r_state == S_SCAN || r_state == S_FLUSH)))
        else $error("result loaded outside drain or into a busy register");
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && o_out_load) |=> (r_valid == '0))
        else $error("store not cleared after drain");
    a_cursor_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIFT) |-> (CNT_W'(r_cur) < r_n))
        else $error("sift cursor beyond heap size");
`endif

endmodule

### dv/tb_top_k_score_selector_unit.sv
// Self-checking testbench of top_k_score_selector_unit: offers, drains and register writes
// are predicted by a min-heap model held here, and every result beat is checked in order.
// Depends on tkss_pkg and the RTL of the block only.
module tb_top_k_score_selector_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tkss_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type    = REQ_OFFER;
    logic [KEY_BITS-1:0]   i_key_id      = '0;
    logic [SCORE_BITS-1:0] i_score       = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic                  o_entry_valid;
    logic [KEY_BITS-1:0]   o_out_key;
    logic [SCORE_BITS-1:0] o_out_score;
    logic [POS_W-1:0]      o_position;
    logic                  o_last;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_K_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int error_count   = 0;

    logic [SCORE_BITS-1:0] kept_score [MAX_K];
    logic [KEY_BITS-1:0]   kept_key   [MAX_K];
    logic                  kept_used  [MAX_K];
    logic [KLIM_W-1:0]     k_reg       = K_LIMIT_RST;
    logic                  ordered_reg = ORDERED_RST;
    t_out_beat             readout_q [$];

    top_k_score_selector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_key_id      (i_key_id),
        .i_score       (i_score),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_valid (o_entry_valid),
        .o_out_key     (o_out_key),
        .o_out_score   (o_out_score),
        .o_position    (o_position),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int slots_in_use();
        if (k_reg == '0) return 1;
        if (int'(k_reg) > MAX_K) return MAX_K;
        return int'(k_reg);
    endfunction

    function automatic void clear_slots();
        for (int i = 0; i < MAX_K; i++) begin
            kept_score[i] = '0;
            kept_key[i]   = '0;
            kept_used[i]  = 1'b0;
        end
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [SCORE_BITS-1:0] s;
        logic [KEY_BITS-1:0]   k;
        logic                  u;
        s = kept_score[a];
        k = kept_key[a];
        u = kept_used[a];
        kept_score[a] = kept_score[b];
        kept_key[a]   = kept_key[b];
        kept_used[a]  = kept_used[b];
        kept_score[b] = s;
        kept_key[b]   = k;
        kept_used[b]  = u;
    endfunction

    function automatic void sift_down(int n);
        int cur;
        int pick;
        cur = 0;
        forever begin
            pick = cur;
            if (2 * cur + 1 < n && kept_score[2 * cur + 1] < kept_score[pick]) pick = 2 * cur + 1;
            if (2 * cur + 2 < n && kept_score[2 * cur + 2] < kept_score[pick]) pick = 2 * cur + 2;
            if (pick == cur) break;
            swap_slots(pick, cur);
            cur = pick;
        end
    endfunction

    function automatic void model_request(logic req, logic [KEY_BITS-1:0] key,
                                          logic [SCORE_BITS-1:0] score);
        int        n;
        int        found;
        t_out_beat beat;
        n     = slots_in_use();
        found = 0;
        if (req == REQ_OFFER) begin
            if (score > kept_score[0]) begin
                kept_score[0] = score;
                kept_key[0]   = key;
                kept_used[0]  = 1'b1;
                sift_down(n);
            end
            return;
        end
        if (ordered_reg) begin
            for (int i = n - 1; i > 0; i--) begin
                swap_slots(0, i);
                sift_down(i);
            end
        end
        for (int i = 0; i < n; i++) begin
            if (kept_used[i]) begin
                beat.entry_valid = 1'b1;
                beat.key         = kept_key[i];
                beat.score       = kept_score[i];
                beat.position    = POS_W'(found);
                beat.last        = 1'b0;
                readout_q.push_back(beat);
                found++;
            end
        end
        if (found == 0) begin
            beat = '0;
            beat.last = 1'b1;
            readout_q.push_back(beat);
        end else begin
            readout_q[readout_q.size() - 1].last = 1'b1;
        end
        clear_slots();
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [SCORE_BITS-1:0] draw_score();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return SCORE_BITS'($urandom_range(7));
            4:       return 32'hFFFF_FFF0 | SCORE_BITS'($urandom_range(15));
            default: return SCORE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [KLIM_W-1:0] draw_k();
        case ($urandom_range(3))
            0:       return KLIM_W'(1);
            1:       return KLIM_W'(MAX_K);
            2:       return KLIM_W'($urandom_range(31));
            default: return KLIM_W'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic send_request(input logic req, input logic [KEY_BITS-1:0] key,
                                input logic [SCORE_BITS-1:0] score);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key_id   <= key;
        i_score    <= score;
        do @(posedge i_clk); while (o_in_stall);
        model_request(req, key, score);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (readout_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_K_LIMIT) k_reg = data;
        else ordered_reg = data[0];
    endtask

    task automatic test_directed();
        send_request(REQ_DRAIN, 16'h0000, 32'h0000_0000);
        send_request(REQ_OFFER, 16'h1234, 32'h0000_0000);
        send_request(REQ_DRAIN, 16'h0000, 32'h0000_0000);
        send_request(REQ_OFFER, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_OFFER, 16'h0000, 32'h0000_0001);
        send_request(REQ_OFFER, 16'h00A5, 32'h0001_0000);
        send_request(REQ_OFFER, 16'h005A, 32'h0001_0000);
        send_request(REQ_DRAIN, 16'hFFFF, 32'hFFFF_FFFF);
        // zero limit acts as a single slot; ties and lower scores bounce off the root
        write_reg(CFG_K_LIMIT, 5'd0);
        write_reg(CFG_ORDERED, 5'b11110);
        send_request(REQ_OFFER, 16'h0010, 32'd7);
        send_request(REQ_OFFER, 16'h0011, 32'd7);
        send_request(REQ_OFFER, 16'h0012, 32'd3);
        send_request(REQ_OFFER, 16'h0013, 32'd9);
        send_request(REQ_DRAIN, 16'h0000, 32'h0000_0000);
        // oversize limit acts as full depth, then shrink it with six of the slots filled
        write_reg(CFG_K_LIMIT, 5'd31);
        send_request(REQ_OFFER, 16'h0101, 32'd5);
        send_request(REQ_OFFER, 16'h0102, 32'd50);
        send_request(REQ_OFFER, 16'h0103, 32'd20);
        send_request(REQ_OFFER, 16'h0104, 32'd2);
        send_request(REQ_OFFER, 16'h0105, 32'd35);
        send_request(REQ_OFFER, 16'h0106, 32'd11);
        write_reg(CFG_K_LIMIT, 5'd3);
        write_reg(CFG_ORDERED, 5'b10101);
        send_request(REQ_OFFER, 16'h0107, 32'd40);
        send_request(REQ_OFFER, 16'h0108, 32'd1);
        send_request(REQ_DRAIN, 16'h0000, 32'h0000_0000);
        send_request(REQ_DRAIN, 16'h0000, 32'h0000_0000);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_K_LIMIT, KLIM_W'(MAX_K));
        write_reg(CFG_ORDERED, 5'd1);
        repeat (MAX_K) send_request(REQ_OFFER, KEY_BITS'($urandom), $urandom | 32'h1);
        // hold the result side so the drain backs up into the input
        hold_request = 300;
        send_request(REQ_DRAIN, KEY_BITS'($urandom), SCORE_BITS'($urandom));
        repeat (20) send_request(REQ_OFFER, KEY_BITS'($urandom), draw_score());
        send_request(REQ_DRAIN, KEY_BITS'($urandom), SCORE_BITS'($urandom));
    endtask

    task automatic test_random(input int n_items, input int snd_pct, input int rcv_pct);
        int sent;
        int burst;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        write_reg(CFG_K_LIMIT, draw_k());
        write_reg(CFG_ORDERED, {4'($urandom), 1'($urandom)});
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(2 * slots_in_use() + 3);
            repeat (burst) send_request(REQ_OFFER, KEY_BITS'($urandom), draw_score());
            sent += burst;
            if ($urandom_range(5) == 0) begin
                write_reg(CFG_K_LIMIT, draw_k());
            end else begin
                send_request(REQ_DRAIN, KEY_BITS'($urandom), SCORE_BITS'($urandom));
                sent++;
            end
        end
        send_request(REQ_DRAIN, KEY_BITS'($urandom), SCORE_BITS'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (readout_q.size() == 0) begin
                $error("result beat with none expected: key %0h score %0h", o_out_key,
                       o_out_score);
                error_count++;
            end else begin
                want = readout_q.pop_front();
                check_field("entry_valid", want.entry_valid, o_entry_valid);
                check_field("out_key", want.key, o_out_key);
                check_field("out_score", want.score, o_out_score);
                check_field("position", want.position, o_position);
                check_field("last", want.last, o_last);
            end
        end
    end

    initial begin
        #10ms;
        $display("tb_top_k_score_selector_unit: FAIL");
        $finish;
    end

    initial begin
        clear_slots();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(70, 15, 64);
        test_random(70, 64, 15);
        test_random(70, 0, 0);
        wait_idle();
        if (error_count == 0) begin
            $display("tb_top_k_score_selector_unit: PASS");
        end else begin
            $display("tb_top_k_score_selector_unit: FAIL");
        end
        $finish;
    end

endmodule
